>>> rtl/cerm_pkg.sv
// Shared types, constants and helpers for the CAN ECU route monitor.
// No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps

package cerm_pkg;

    localparam int MAX_ECUS_DEF     = 16;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int MAX_BEATS_DEF    = 8;
    localparam int RES_CAP          = 16;
    localparam int QUEUE_DEPTH      = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_FIRST_ID = 3'd0;
    localparam logic [2:0] CFG_LAST_ID  = 3'd1;
    localparam logic [2:0] CFG_CODE     = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT  = 3'd3;
    localparam logic [2:0] CFG_PERIOD   = 3'd4;

    typedef enum logic [2:0] {
        CLS_IDLE = 3'd0,
        CLS_DISC = 3'd1,
        CLS_TELE = 3'd2,
        CLS_SKIP = 3'd3
    } cls_t;

    typedef enum logic [2:0] {
        KIND_DISCOVERED = 3'd0,
        KIND_CONFLICT   = 3'd1,
        KIND_FULL       = 3'd2,
        KIND_ONLINE     = 3'd3,
        KIND_HEARTBEAT  = 3'd4,
        KIND_STATUS     = 3'd5,
        KIND_TELEMETRY  = 3'd6,
        KIND_UNMATCHED  = 3'd7
    } kind_t;

    typedef struct packed {
        logic [28:0] first_id;
        logic [28:0] last_id;
        logic [7:0]  code;
        logic [15:0] timeout;
        logic [9:0]  period;
    } cfg_t;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  channel;
        logic [28:0] frame_id;
        logic [6:0]  payload_len;
        logic [2:0]  beat_index;
        logic [63:0] beat_data;
        logic        beat_last;
        logic        drop;
        logic        disc_hit;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ecu;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic        online;
        logic        last;
    } res_t;

    function automatic logic [7:0] byte_of(input logic [63:0] d, input int k);
        return d[63-8*k -: 8];
    endfunction

    function automatic res_t mk_res(input kind_t k, input logic [7:0] e,
                                    input logic [31:0] a, input logic [31:0] b,
                                    input logic on, input logic lst);
        res_t r;
        r.kind    = k;
        r.ecu     = e;
        r.value_a = a;
        r.value_b = b;
        r.online  = on;
        r.last    = lst;
        return r;
    endfunction

endpackage

>>> rtl/cerm_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on cerm_pkg.
`timescale 1ns / 1ps

module cerm_front import cerm_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_BEATS    = MAX_BEATS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [1:0]  s_channel,
    input  logic [28:0] s_frame_id,
    input  logic [6:0]  s_payload_len,
    input  logic [2:0]  s_beat_index,
    input  logic [63:0] s_beat_data,
    input  logic        s_beat_last,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t            q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    item_t            in_item;
    logic             push;

    always_comb begin
        in_item.cmd         = s_cmd;
        in_item.channel     = s_channel;
        in_item.frame_id    = s_frame_id;
        in_item.payload_len = s_payload_len;
        in_item.beat_index  = s_beat_index;
        in_item.beat_data   = s_beat_data;
        in_item.beat_last   = s_beat_last;
        in_item.drop        = (32'(s_channel) >= MAX_CHANNELS) ||
                              (32'(s_beat_index) >= MAX_BEATS);
        in_item.disc_hit    = (s_frame_id >= cfg.first_id) && (s_frame_id <= cfg.last_id) &&
                              (s_payload_len == 7'd10) && (s_beat_data[63:56] == cfg.code);
    end

    assign s_ready = (cnt_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/cerm_back.sv
// Back end: route table, frame state, tick scan and the result register.
// Depends on cerm_pkg; fed by cerm_front.
`timescale 1ns / 1ps

module cerm_back import cerm_pkg::*; #(
    parameter int MAX_ECUS = MAX_ECUS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_res
);
    localparam int IDX_W = (MAX_ECUS > 1) ? $clog2(MAX_ECUS) : 1;
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_MATCH  = 7'b0000100,
        S_DISC   = 7'b0001000,
        S_EMIT   = 7'b0010000,
        S_TSCAN  = 7'b0100000,
        S_TEMIT  = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    item_t               item_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [MAX_ECUS-1:0] mask_reg, mask_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_reg, free_next;
    res_t                pend_reg, pend_next, pend2_reg, pend2_next;
    logic                pend2_v_reg, pend2_v_next;
    cls_t                class_reg, class_next;
    logic [7:0]          matched_key_reg, matched_key_next;
    logic [63:0]         first_reg, first_next;
    logic [31:0]         ms_reg, ms_next;
    logic [9:0]          cc_reg, cc_next, cc_inc;
    logic                m_valid_reg;
    res_t                m_res_reg;

    logic [MAX_ECUS-1:0] entry_valid_reg;
    logic [MAX_ECUS-1:0] entry_online_reg;
    logic [7:0]          entry_key_reg       [MAX_ECUS];
    logic [1:0]          entry_channel_reg   [MAX_ECUS];
    logic [63:0]         entry_ids_reg       [MAX_ECUS];
    logic [31:0]         entry_last_beat_reg [MAX_ECUS];

    logic [IDX_W-1:0] ei, disc_slot;
    logic             e_valid, e_online, ch_hit, hb_hit, st_hit, te_hit, at_end, slot_free;
    logic [7:0]       e_key, b0, dkey;
    logic [63:0]      e_ids, d;
    logic             hb_we, on_set, on_clr, disc_we, out_load;
    res_t             out_res;
    logic             tmo_hit;
    logic [MAX_ECUS-1:0] rest;

    assign ei        = idx_reg[IDX_W-1:0];
    assign e_valid   = entry_valid_reg[ei];
    assign e_online  = entry_online_reg[ei];
    assign e_key     = entry_key_reg[ei];
    assign e_ids     = entry_ids_reg[ei];
    assign d         = item_reg.beat_data;
    assign b0        = byte_of(d, 0);
    assign dkey      = byte_of(first_reg, 1);
    assign ch_hit    = e_valid && (entry_channel_reg[ei] == item_reg.channel);
    assign hb_hit    = ch_hit && (item_reg.frame_id == {13'd0, e_ids[31:16]}) &&
                       (item_reg.payload_len >= 7'd3) && (b0 == e_key);
    assign st_hit    = ch_hit && (item_reg.frame_id == {13'd0, e_ids[47:32]}) &&
                       (item_reg.payload_len >= 7'd2);
    assign te_hit    = ch_hit && (item_reg.frame_id == {13'd0, e_ids[15:0]}) &&
                       (item_reg.payload_len != 7'd0) && (item_reg.payload_len[2:0] == 3'd0);
    assign at_end    = (idx_reg == CNT_W'(MAX_ECUS - 1));
    assign slot_free = !m_valid_reg || m_ready;
    assign tmo_hit   = e_valid && e_online &&
                       ((ms_reg - entry_last_beat_reg[ei]) > {16'd0, cfg.timeout});
    assign cc_inc    = cc_reg + 10'd1;
    assign disc_slot = free_found_reg ? free_reg : ei;
    assign rest      = mask_reg & ~(MAX_ECUS'(1) << ei);

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        mask_next        = mask_reg;
        free_found_next  = free_found_reg;
        free_next        = free_reg;
        pend_next        = pend_reg;
        pend2_next       = pend2_reg;
        pend2_v_next     = pend2_v_reg;
        class_next       = class_reg;
        matched_key_next = matched_key_reg;
        first_next       = first_reg;
        ms_next          = ms_reg;
        cc_next          = cc_reg;
        q_pop            = 1'b0;
        hb_we            = 1'b0;
        on_set           = 1'b0;
        on_clr           = 1'b0;
        disc_we          = 1'b0;
        out_load         = 1'b0;
        out_res          = pend_reg;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_IDLE;
                idx_next   = '0;
                if (item_reg.cmd) begin
                    // advance the millisecond clock; scan when the period is reached
                    ms_next = ms_reg + 32'd1;
                    if (cc_inc < cfg.period) begin
                        cc_next = cc_inc;
                    end else begin
                        cc_next    = '0;
                        mask_next  = '0;
                        state_next = S_TSCAN;
                    end
                end else if (item_reg.drop) begin
                    state_next = S_IDLE;
                end else if (item_reg.beat_index == 3'd0) begin
                    if (item_reg.disc_hit) begin
                        first_next = d;
                        class_next = item_reg.beat_last ? CLS_IDLE : CLS_DISC;
                    end else begin
                        state_next = S_MATCH;
                    end
                end else begin
                    class_next = item_reg.beat_last ? CLS_IDLE : class_reg;
                    case (class_reg)
                        CLS_DISC: begin
                            if (item_reg.beat_index == 3'd1) begin
                                class_next      = item_reg.beat_last ? CLS_IDLE : CLS_SKIP;
                                free_found_next = 1'b0;
                                state_next      = S_DISC;
                            end
                        end
                        CLS_TELE: begin
                            if ({1'b0, item_reg.beat_index, 3'd0} < item_reg.payload_len) begin
                                pend_next    = mk_res(KIND_TELEMETRY, matched_key_reg,
                                                      d[63:32], d[31:0], 1'b0, 1'b1);
                                pend2_v_next = 1'b0;
                                state_next   = S_EMIT;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MATCH: begin
                pend2_v_next = 1'b0;
                class_next   = item_reg.beat_last ? CLS_IDLE : CLS_SKIP;
                if (hb_hit) begin
                    hb_we      = 1'b1;
                    state_next = S_EMIT;
                    if (!e_online) begin
                        on_set       = 1'b1;
                        pend_next    = mk_res(KIND_ONLINE, e_key, '0, '0, 1'b1, 1'b0);
                        pend2_next   = mk_res(KIND_HEARTBEAT, e_key, {24'd0, byte_of(d, 2)},
                                              {24'd0, byte_of(d, 1)}, 1'b0, 1'b1);
                        pend2_v_next = 1'b1;
                    end else begin
                        pend_next = mk_res(KIND_HEARTBEAT, e_key, {24'd0, byte_of(d, 2)},
                                           {24'd0, byte_of(d, 1)}, 1'b0, 1'b1);
                    end
                end else if (st_hit) begin
                    pend_next  = mk_res(KIND_STATUS, e_key, {24'd0, b0},
                                        {24'd0, byte_of(d, 1)}, 1'b0, 1'b1);
                    state_next = S_EMIT;
                end else if (te_hit) begin
                    pend_next        = mk_res(KIND_TELEMETRY, e_key, d[63:32], d[31:0],
                                              1'b0, 1'b1);
                    matched_key_next = e_key;
                    class_next       = item_reg.beat_last ? CLS_IDLE : CLS_TELE;
                    state_next       = S_EMIT;
                end else if (at_end) begin
                    pend_next  = mk_res(KIND_UNMATCHED, 8'd0, {3'd0, item_reg.frame_id},
                                        {30'd0, item_reg.channel}, 1'b0, 1'b1);
                    state_next = S_EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DISC: begin
                pend2_v_next = 1'b0;
                if (e_valid && (e_key == dkey)) begin
                    if (entry_channel_reg[ei] != item_reg.channel) begin
                        pend_next  = mk_res(KIND_CONFLICT, dkey, {16'd0, first_reg[47:32]},
                                            {30'd0, item_reg.channel}, 1'b0, 1'b1);
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    if (!e_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_next       = ei;
                    end
                    if (at_end) begin
                        state_next = S_EMIT;
                        if (free_found_reg || !e_valid) begin
                            disc_we   = 1'b1;
                            pend_next = mk_res(KIND_DISCOVERED, dkey, {16'd0, first_reg[47:32]},
                                               {30'd0, item_reg.channel}, 1'b0, 1'b1);
                        end else begin
                            pend_next = mk_res(KIND_FULL, dkey, {16'd0, first_reg[47:32]},
                                               {30'd0, item_reg.channel}, 1'b0, 1'b1);
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    if (pend2_v_reg) begin
                        pend_next    = pend2_reg;
                        pend2_v_next = 1'b0;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_TSCAN: begin
                mask_next[ei] = tmo_hit;
                if (at_end) begin
                    idx_next   = '0;
                    cnt_next   = '0;
                    state_next = S_TEMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_TEMIT: begin
                out_res = mk_res(KIND_ONLINE, e_key, '0, '0, 1'b0,
                                 (cnt_reg == 5'(RES_CAP - 1)) || (rest == '0));
                if ((mask_reg == '0) || (cnt_reg == 5'(RES_CAP))) begin
                    state_next = S_IDLE;
                end else if (!mask_reg[ei]) begin
                    idx_next = idx_reg + 1'b1;
                end else if (slot_free) begin
                    out_load      = 1'b1;
                    on_clr        = 1'b1;
                    mask_next[ei] = 1'b0;
                    cnt_next      = cnt_reg + 5'd1;
                    idx_next      = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            mask_reg         <= '0;
            free_found_reg   <= 1'b0;
            pend2_v_reg      <= 1'b0;
            class_reg        <= CLS_IDLE;
            first_reg        <= '0;
            ms_reg           <= '0;
            cc_reg           <= '0;
            m_valid_reg      <= 1'b0;
            entry_valid_reg  <= '0;
            entry_online_reg <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            mask_reg       <= mask_next;
            free_found_reg <= free_found_next;
            pend2_v_reg    <= pend2_v_next;
            class_reg      <= class_next;
            first_reg      <= first_next;
            ms_reg         <= ms_next;
            cc_reg         <= cc_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (on_set) begin
                entry_online_reg[ei] <= 1'b1;
            end
            if (on_clr) begin
                entry_online_reg[ei] <= 1'b0;
            end
            if (disc_we) begin
                entry_valid_reg[disc_slot]  <= 1'b1;
                entry_online_reg[disc_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        free_reg        <= free_next;
        pend_reg        <= pend_next;
        pend2_reg       <= pend2_next;
        matched_key_reg <= matched_key_next;
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (out_load) begin
            m_res_reg <= out_res;
        end
        if (hb_we) begin
            entry_last_beat_reg[ei] <= ms_reg;
        end
        if (disc_we) begin
            entry_key_reg[disc_slot]       <= dkey;
            entry_channel_reg[disc_slot]   <= item_reg.channel;
            entry_ids_reg[disc_slot]       <= {first_reg[47:0], d[63:48]};
            entry_last_beat_reg[disc_slot] <= '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TEMIT) |-> (cnt_reg <= 5'(RES_CAP)))
        else $error("tick scan exceeded result cap");

    a_pend2_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend2_v_reg)
        else $error("second pending result left behind");

    a_disc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        disc_we |-> !entry_valid_reg[disc_slot])
        else $error("discovery overwrote a valid route");

endmodule

>>> rtl/can_ecu_route_monitor_core.sv
// Top level of the CAN ECU route monitor: configuration registers and the
// front/back split. Depends on cerm_pkg, cerm_front and cerm_back.
`timescale 1ns / 1ps

// The monitor takes received CAN frames as 8-byte beats (s_cmd = 0) and 1 ms ticks
// (s_cmd = 1) and returns results on the m_ channel, m_last marking the final result
// of each input transaction that yields one. Discovery responses add routes to a
// table of MAX_ECUS entries; later frames are matched against it lowest entry first.
// A two-deep input queue sits in front of the sequencer, and a result register sits
// behind it, so input is taken while a result waits. Each transaction is popped and
// decoded; a beat-0 frame then walks the table one entry per cycle until it matches
// or reaches the last entry and emits its results; discovery completion walks it
// likewise until it finds the key or reaches the last entry and emits any result; a
// scanning tick walks every entry to build the timeout mask, then steps through the
// entries up to the last expiring one, emitting a result for each. A stalled receiver
// holds up every result. The single read port on the route table makes each walk go
// one entry at a time. Configuration writes are always accepted (cfg_ready is tied
// high) and must be issued while the block is idle.

module can_ecu_route_monitor_core import cerm_pkg::*; #(
    parameter int MAX_ECUS     = MAX_ECUS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_BEATS    = MAX_BEATS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input transactions
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [1:0]  s_channel,
    input  logic [28:0] s_frame_id,
    input  logic        s_is_fd,
    input  logic [6:0]  s_payload_len,
    input  logic [2:0]  s_beat_index,
    input  logic [63:0] s_beat_data,
    input  logic        s_beat_last,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_ecu,
    output logic [31:0] m_value_a,
    output logic [31:0] m_value_b,
    output logic        m_online,
    output logic        m_last
);
    cfg_t  cfg_reg;
    logic  q_valid, q_pop;
    item_t q_item;
    res_t  res;

    assign cfg_ready = 1'b1;

    // hold configuration; drop writes to unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_id <= 29'h7A1;
            cfg_reg.last_id  <= 29'h7AF;
            cfg_reg.code     <= 8'hD2;
            cfg_reg.timeout  <= 16'd500;
            cfg_reg.period   <= 10'd100;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FIRST_ID: cfg_reg.first_id <= cfg_data[28:0];
                CFG_LAST_ID:  cfg_reg.last_id  <= cfg_data[28:0];
                CFG_CODE:     cfg_reg.code     <= cfg_data[7:0];
                CFG_TIMEOUT:  cfg_reg.timeout  <= cfg_data[15:0];
                CFG_PERIOD:   cfg_reg.period   <= cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // s_is_fd carries no meaning for routing; it is accepted and not stored
    cerm_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_BEATS    (MAX_BEATS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_channel     (s_channel),
        .s_frame_id    (s_frame_id),
        .s_payload_len (s_payload_len),
        .s_beat_index  (s_beat_index),
        .s_beat_data   (s_beat_data),
        .s_beat_last   (s_beat_last),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    cerm_back #(
        .MAX_ECUS (MAX_ECUS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_kind    = res.kind;
    assign m_ecu     = res.ecu;
    assign m_value_a = res.value_a;
    assign m_value_b = res.value_b;
    assign m_online  = res.online;
    assign m_last    = res.last;

endmodule
